// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that ante implies cons on the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that ante implies cons on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/nkdt_pkg.sv
// ---------------------------------------------------------------------------
// nkdt_pkg
// Types, constants and helpers for the name keyed directory table.
// ---------------------------------------------------------------------------
package nkdt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int NAME_BYTES    = 8;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KEY_W         = 64;
  localparam int SECTOR_W      = 16;
  localparam int SLOT_W        = 4;
  localparam int CMD_W         = 2;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [SECTOR_W-1:0] sector_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    key_t             key_name;
    sector_t          new_sector;
  } in_t;

  typedef struct packed {
    logic              ok;
    sector_t           sector;
    logic [SLOT_W-1:0] slot;
  } out_t;

  // Search token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic    active;
    logic    hit;
    idx_t    hit_idx;
    sector_t hit_sector;
    logic    free;
    idx_t    free_idx;
  } tok_t;

  // Update broadcast to all cells when the token leaves the chain.
  typedef struct packed {
    logic    set;
    logic    clr;
    idx_t    idx;
    key_t    name;
    sector_t sector;
  } wr_t;

  // Keep bytes up to the first zero byte, within NAME_BYTES; clear the rest.
  function automatic key_t canon_key(input key_t raw);
    key_t kept;
    logic live;
    kept = '0;
    live = 1'b1;
    for (int p = 0; p < KEY_W / 8; p++) begin
      if (p >= NAME_BYTES || raw[8*p +: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        kept[8*p +: 8] = raw[8*p +: 8];
      end
    end
    return kept;
  endfunction

endpackage

// File: hw/rtl/nkdt_cell.sv
// ---------------------------------------------------------------------------
// nkdt_cell
// One table slot: holds valid, name and sector, compares against the key and
// merges its hit and free status into the passing search token.
// ---------------------------------------------------------------------------
module nkdt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  nkdt_pkg::idx_t cell_idx,
  input  nkdt_pkg::key_t key,
  input  nkdt_pkg::tok_t tok_in,
  input  nkdt_pkg::wr_t  wr,
  output nkdt_pkg::tok_t tok_out
);

  logic              valid_r;
  logic              valid_nxt;
  nkdt_pkg::key_t    name_r;
  nkdt_pkg::sector_t sector_r;
  nkdt_pkg::tok_t    tok_r;
  nkdt_pkg::tok_t    tok_nxt;
  logic              match;
  logic              sel;

  assign match = valid_r && (name_r == key);
  assign sel   = (wr.idx == cell_idx);

  // Earlier cells have priority: keep an earlier hit or free slot.
  always_comb begin
    tok_nxt = tok_in;
    if (!tok_in.hit && match) begin
      tok_nxt.hit        = 1'b1;
      tok_nxt.hit_idx    = cell_idx;
      tok_nxt.hit_sector = sector_r;
    end
    if (!tok_in.free && !valid_r) begin
      tok_nxt.free     = 1'b1;
      tok_nxt.free_idx = cell_idx;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (sel && wr.set) begin
      valid_nxt = 1'b1;
    end else if (sel && wr.clr) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.set) begin
      name_r   <= wr.name;
      sector_r <= wr.sector;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: hw/rtl/name_keyed_directory_table_top.sv
// ---------------------------------------------------------------------------
// name_keyed_directory_table_top
// Directory table searched by name: find, add and remove over a chain of
// slot cells that a search token walks one cell per cycle.
// ---------------------------------------------------------------------------
// Channel  Ports                        Handshake
// input    in_item (cmd/key/sector)     start high, busy low at the edge
// result   out_item (ok/sector/slot)    out_valid high for one cycle
//
// The token walk through the cell chain, one cell per cycle, lies between
// accept and result. A new transaction can be accepted in the cycle the
// result is shown, not before, so transactions never overlap.
// Reset empties the table at once; there is no clearing pass.
// The receiver cannot stall; busy is the only back pressure.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module name_keyed_directory_table_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  nkdt_pkg::in_t  in_item,
  output logic           out_valid,
  output nkdt_pkg::out_t out_item
);

  logic                         busy_r;
  logic                         busy_nxt;
  logic                         launch_r;
  logic [nkdt_pkg::CMD_W-1:0]   cmd_r;
  nkdt_pkg::key_t               key_r;
  nkdt_pkg::sector_t            nsec_r;
  logic                         out_valid_r;
  nkdt_pkg::out_t               out_r;
  nkdt_pkg::out_t               out_nxt;
  nkdt_pkg::wr_t                wr;
  nkdt_pkg::tok_t               tok_head;
  nkdt_pkg::tok_t               tok [nkdt_pkg::TABLE_ENTRIES+1];
  nkdt_pkg::tok_t               last;
  logic [nkdt_pkg::TABLE_ENTRIES-1:0] tok_act;
  logic                         accept;

  assign accept = start && !busy_r;
  assign last   = tok[nkdt_pkg::TABLE_ENTRIES];

  // Fresh token enters the chain the cycle after accept.
  always_comb begin
    tok_head        = '0;
    tok_head.active = launch_r;
  end

  assign tok[0] = tok_head;

  for (genvar i = 0; i < nkdt_pkg::TABLE_ENTRIES; i++) begin : g_cell
    nkdt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (nkdt_pkg::idx_t'(i)),
      .key      (key_r),
      .tok_in   (tok[i]),
      .wr       (wr),
      .tok_out  (tok[i+1])
    );
    assign tok_act[i] = tok[i+1].active;
  end

  // Resolve the command when the token leaves the last cell.
  always_comb begin
    out_nxt   = '0;
    wr        = '0;
    wr.name   = key_r;
    wr.sector = nsec_r;
    if (last.active) begin
      unique case (cmd_r)
        nkdt_pkg::CMD_FIND: begin
          if (last.hit) begin
            out_nxt.ok     = 1'b1;
            out_nxt.sector = last.hit_sector;
            out_nxt.slot   = nkdt_pkg::SLOT_W'(last.hit_idx);
          end
        end
        nkdt_pkg::CMD_ADD: begin
          if (!last.hit && last.free) begin
            wr.set       = 1'b1;
            wr.idx       = last.free_idx;
            out_nxt.ok   = 1'b1;
            out_nxt.slot = nkdt_pkg::SLOT_W'(last.free_idx);
          end
        end
        nkdt_pkg::CMD_REMOVE: begin
          if (last.hit) begin
            wr.clr       = 1'b1;
            wr.idx       = last.hit_idx;
            out_nxt.ok   = 1'b1;
            out_nxt.slot = nkdt_pkg::SLOT_W'(last.hit_idx);
          end
        end
        default: begin
          out_nxt = '0;
        end
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (last.active) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      launch_r    <= accept;
      out_valid_r <= last.active;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_item.cmd;
      key_r  <= nkdt_pkg::canon_key(in_item.key_name);
      nsec_r <= in_item.new_sector;
    end
    if (last.active) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_CLK(a_one_token, $onehot0({tok_act, launch_r}), "more than one token in the chain")
  `ASSERT_IMPL(a_token_busy, launch_r || (|tok_act), busy_r, "token in flight while idle")
  `ASSERT_NEXT(a_accept_busy, accept, busy_r && launch_r, "accepted transaction not launched")
  `ASSERT_IMPL(a_fail_zero, out_valid_r && !out_r.ok, out_r.sector == '0 && out_r.slot == '0,
               "failed transaction with nonzero payload")
  `ASSERT_IMPL(a_one_write, 1'b1, !(wr.set && wr.clr), "set and clear in the same cycle")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the name keyed directory table. A queue of find,
// add and remove transactions is built up front: a short directed run over
// the empty, full and duplicate cases, then random phases that lean toward
// filling the table, draining it or neither. The driver predicts each accepted
// transaction against a local copy of the table; the monitor compares every
// result strobe with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;

  localparam logic [nkdt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_OPS  = 1500;
  localparam int CALM_TAIL   = 150;
  localparam int STALL_LIMIT = 1000;
  localparam int POOL_NAMES  = 40;

  typedef struct {
    nkdt_pkg::in_t item;
    int unsigned   gap;
    bit            drain;
  } pend_op_t;

  logic           clk;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  logic           out_valid;
  nkdt_pkg::in_t  in_item = '0;
  nkdt_pkg::out_t out_item;

  // Local copy of the table, advanced as transactions are accepted
  logic              tbl_valid  [nkdt_pkg::TABLE_ENTRIES];
  nkdt_pkg::key_t    tbl_name   [nkdt_pkg::TABLE_ENTRIES];
  nkdt_pkg::sector_t tbl_sector [nkdt_pkg::TABLE_ENTRIES];

  pend_op_t       pending_ops[$];
  nkdt_pkg::out_t dir_expect[$];
  nkdt_pkg::key_t present_names[$];
  nkdt_pkg::key_t name_pool[$];

  int             n_total = 0;
  int             n_acc = 0;
  int             n_got = 0;
  int             n_err = 0;
  int unsigned    gap_left = 0;
  int             idle_cycles = 0;
  logic           drv_hold;
  nkdt_pkg::out_t exp_res;

  name_keyed_directory_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Keep bytes up to the first zero byte, within NAME_BYTES; zero the rest.
  function automatic nkdt_pkg::key_t canon_name(nkdt_pkg::key_t raw);
    nkdt_pkg::key_t k;
    logic live;
    k = '0;
    live = 1'b1;
    for (int b = 0; b < nkdt_pkg::KEY_W / 8; b++) begin
      if (b >= nkdt_pkg::NAME_BYTES || raw[8*b +: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        k[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return k;
  endfunction

  function automatic nkdt_pkg::out_t predict_dir_op(nkdt_pkg::in_t op);
    nkdt_pkg::key_t k;
    int             hit;
    int             free_s;
    nkdt_pkg::out_t r;
    k = canon_name(op.key_name);
    hit = -1;
    free_s = -1;
    r = '0;
    // Scan downward so the lowest matching and lowest free slots win
    for (int s = nkdt_pkg::TABLE_ENTRIES - 1; s >= 0; s--) begin
      if (tbl_valid[s] && tbl_name[s] == k) hit = s;
      if (!tbl_valid[s]) free_s = s;
    end
    case (op.cmd)
      nkdt_pkg::CMD_FIND: begin
        if (hit >= 0) begin
          r.ok = 1'b1;
          r.sector = tbl_sector[hit];
          r.slot = hit[nkdt_pkg::SLOT_W-1:0];
        end
      end
      nkdt_pkg::CMD_ADD: begin
        if (hit < 0 && free_s >= 0) begin
          tbl_valid[free_s] = 1'b1;
          tbl_name[free_s] = k;
          tbl_sector[free_s] = op.new_sector;
          r.ok = 1'b1;
          r.slot = free_s[nkdt_pkg::SLOT_W-1:0];
        end
      end
      nkdt_pkg::CMD_REMOVE: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          r.ok = 1'b1;
          r.slot = hit[nkdt_pkg::SLOT_W-1:0];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Fill the bytes past the terminator with noise; the name stays the same.
  function automatic nkdt_pkg::key_t pad_garbage(nkdt_pkg::key_t k);
    nkdt_pkg::key_t d;
    logic past;
    d = k;
    past = 1'b0;
    for (int b = 0; b < nkdt_pkg::KEY_W / 8; b++) begin
      if (past) begin
        d[8*b +: 8] = 8'($urandom_range(0, 255));
      end else if (k[8*b +: 8] == 8'h00) begin
        past = 1'b1;
      end
    end
    return d;
  endfunction

  function automatic nkdt_pkg::key_t fresh_name();
    nkdt_pkg::key_t k;
    int   len;
    k = '0;
    len = $urandom_range(0, 8);
    for (int b = 0; b < len; b++) begin
      k[8*b +: 8] = 8'($urandom_range(1, 255));
    end
    return k;
  endfunction

  // Queue a transaction and track which names the table will hold.
  task automatic push_op(logic [nkdt_pkg::CMD_W-1:0] c, nkdt_pkg::key_t key,
                         nkdt_pkg::sector_t sec, int unsigned gap, bit drain);
    pend_op_t       p;
    nkdt_pkg::key_t k;
    int             at;
    p.item.cmd = c;
    p.item.key_name = key;
    p.item.new_sector = sec;
    p.gap = gap;
    p.drain = drain;
    pending_ops.push_back(p);
    k = canon_name(key);
    at = -1;
    foreach (present_names[i]) begin
      if (present_names[i] == k) at = i;
    end
    if (c == nkdt_pkg::CMD_ADD && at < 0 && present_names.size() < nkdt_pkg::TABLE_ENTRIES) begin
      present_names.push_back(k);
    end else if (c == nkdt_pkg::CMD_REMOVE && at >= 0) begin
      present_names.delete(at);
    end
  endtask

  task automatic report_mismatch(string field, int unsigned e, int unsigned a);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, e, a);
    n_err++;
  endtask

  initial begin : stim
    int                         phase_left;
    int                         mix;
    int                         roll;
    int                         p_add;
    int                         p_rem;
    int                         p_find;
    bit                         idle_on;
    bit                         new_phase;
    int unsigned                gap;
    logic [nkdt_pkg::CMD_W-1:0] c;
    nkdt_pkg::key_t             key;
    nkdt_pkg::sector_t          sec;

    foreach (tbl_valid[s]) tbl_valid[s] = 1'b0;

    // Empty table, then a small table with the widest and narrowest names
    push_op(nkdt_pkg::CMD_FIND,   64'h0, 16'h0000, 0, 0);
    push_op(nkdt_pkg::CMD_REMOVE, 64'h41, 16'hFFFF, 0, 0);
    push_op(nkdt_pkg::CMD_ADD,    64'h41, 16'hFFFF, 0, 0);
    push_op(nkdt_pkg::CMD_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 0, 0);
    push_op(nkdt_pkg::CMD_ADD,    64'hFFFF_FFFF_FFFF_0041, 16'h1234, 0, 0);
    push_op(nkdt_pkg::CMD_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 0, 0);
    push_op(CMD_UNUSED,           64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 0, 0);
    // Fill the remaining slots, the empty name among them
    for (int i = 0; i < nkdt_pkg::TABLE_ENTRIES - 2; i++) begin
      key = (i == 0) ? 64'h0 : {56'h0, 8'(8'h41 + i)};
      push_op(nkdt_pkg::CMD_ADD, key, 16'(i * 16'h1111), 0, 0);
    end
    push_op(nkdt_pkg::CMD_ADD,    64'h5A, 16'hBEEF, 0, 0);
    push_op(nkdt_pkg::CMD_REMOVE, 64'hA5A5_0000_0000_0041, 16'h0000, 0, 0);
    push_op(nkdt_pkg::CMD_FIND,   64'h41, 16'h0000, 0, 0);
    push_op(nkdt_pkg::CMD_ADD,    64'h0102_0304_0506_0708, 16'h1234, 0, 0);

    for (int i = 0; i < POOL_NAMES; i++) begin
      name_pool.push_back(fresh_name());
    end

    phase_left = 0;
    idle_on = 1'b0;
    new_phase = 1'b0;
    p_add = 0;
    p_rem = 0;
    p_find = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 150);
        mix = $urandom_range(0, 2);
        // Lean toward filling, draining or neither
        case (mix)
          0: begin p_add = 60; p_rem = 15; p_find = 20; end
          1: begin p_add = 15; p_rem = 60; p_find = 20; end
          default: begin p_add = 35; p_rem = 35; p_find = 25; end
        endcase
        idle_on = ($urandom_range(0, 3) != 0);
        new_phase = 1'b1;
      end
      phase_left--;

      roll = $urandom_range(0, 99);
      if (roll < p_add) c = nkdt_pkg::CMD_ADD;
      else if (roll < p_add + p_rem) c = nkdt_pkg::CMD_REMOVE;
      else if (roll < p_add + p_rem + p_find) c = nkdt_pkg::CMD_FIND;
      else c = CMD_UNUSED;

      roll = $urandom_range(0, 99);
      if (present_names.size() > 0 && roll < ((c == nkdt_pkg::CMD_ADD) ? 15 : 60)) begin
        key = present_names[$urandom_range(0, present_names.size() - 1)];
      end else if (roll < 85) begin
        key = name_pool[$urandom_range(0, POOL_NAMES - 1)];
      end else if (c == nkdt_pkg::CMD_ADD) begin
        key = fresh_name();
      end else begin
        key = {$urandom, $urandom};
      end
      if ($urandom_range(0, 9) < 3) key = pad_garbage(key);

      roll = $urandom_range(0, 9);
      sec = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);

      gap = 0;
      if (idle_on && n < RANDOM_OPS - CALM_TAIL && $urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, 19);
      end
      push_op(c, key, sec, gap, new_phase);
      new_phase = 1'b0;
    end
    n_total = pending_ops.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (n_acc < n_total || n_got != n_acc) @(posedge clk);
    repeat (nkdt_pkg::TABLE_ENTRIES + 4) @(posedge clk);
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Driver: predict on accept, then idle, wait for drain, or present the next
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      drv_hold = start;
      if (start && !busy) begin
        dir_expect.push_back(predict_dir_op(in_item));
        n_acc++;
        drv_hold = 1'b0;
        if (pending_ops.size() > 0) gap_left = pending_ops[0].gap;
      end
      if (!drv_hold) begin
        // Count idle cycles only while the block could take a transaction
        if (gap_left > 0) begin
          if (!busy) gap_left--;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain && n_acc != n_got)) begin
          in_item <= pending_ops[0].item;
          pending_ops.pop_front();
          drv_hold = 1'b1;
        end
      end
      start <= drv_hold;
    end
  end

  // Monitor: every strobe must match the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_got <= n_got + 1;
      if (dir_expect.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual ok %0h sector %0h slot %0h",
                 $time, out_item.ok, out_item.sector, out_item.slot);
        n_err++;
      end else begin
        exp_res = dir_expect.pop_front();
        if (out_item.ok !== exp_res.ok) begin
          report_mismatch("ok", 32'(exp_res.ok), 32'(out_item.ok));
        end
        if (out_item.sector !== exp_res.sector) begin
          report_mismatch("sector", 32'(exp_res.sector), 32'(out_item.sector));
        end
        if (out_item.slot !== exp_res.slot) begin
          report_mismatch("slot", 32'(exp_res.slot), 32'(out_item.slot));
        end
      end
    end
  end

  // Watchdog: abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/nkdt_pkg.sv
hw/rtl/nkdt_cell.sv
hw/rtl/name_keyed_directory_table_top.sv
dv/tb_top.sv
